// File: rtl/core/iidl_pkg.sv
package iidl_pkg;

  localparam int CAPACITY_DEF  = 64;
  localparam int WORD_BITS_DEF = 32;

  localparam int OP_BITS    = 3;
  localparam int POS_BITS   = 7;
  localparam int VALUE_BITS = 32;
  localparam int COUNT_BITS = 7;

  localparam logic [OP_BITS-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_BITS-1:0] OP_DELETE = 3'd1;
  localparam logic [OP_BITS-1:0] OP_GET    = 3'd2;
  localparam logic [OP_BITS-1:0] OP_SET    = 3'd3;
  localparam logic [OP_BITS-1:0] OP_CLEAR  = 3'd4;

  typedef struct packed {
    logic latch;
    logic load_err;
    logic set_wr;
    logic clr_cnt;
    logic idx_from_cnt;
    logic idx_from_pos;
    logic rd_pos;
    logic rd_prev;
    logic rd_next;
    logic wr_up;
    logic wr_dn;
    logic ins_put;
    logic res_cap;
    logic cnt_dec;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic is_ins;
    logic is_del;
    logic is_get;
    logic is_set;
    logic is_clr;
    logic ins_at_pos;
    logic del_last;
  } sts_t;

endpackage

// File: rtl/core/iidl_datapath.sv
module iidl_datapath #(
  parameter int CAPACITY  = iidl_pkg::CAPACITY_DEF,
  parameter int WORD_BITS = iidl_pkg::WORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  iidl_pkg::cmd_t                  cmd,
  output iidl_pkg::sts_t                  sts,
  input  logic [iidl_pkg::OP_BITS-1:0]    in_op,
  input  logic [iidl_pkg::POS_BITS-1:0]   in_position,
  input  logic [iidl_pkg::VALUE_BITS-1:0] in_value_in,
  output logic [iidl_pkg::VALUE_BITS-1:0] out_value_out,
  output logic [iidl_pkg::COUNT_BITS-1:0] out_entry_count,
  output logic                            out_range_error
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > iidl_pkg::POS_BITS) ? CW : iidl_pkg::POS_BITS;

  logic [WORD_BITS-1:0] mem [CAPACITY];
  logic [WORD_BITS-1:0] rdata_r;

  logic [iidl_pkg::OP_BITS-1:0] op_r;
  logic [CMPW-1:0]              pos_r;
  logic [WORD_BITS-1:0]         val_r;
  logic [CW-1:0]                count_r;
  logic [CW-1:0]                idx_r;
  logic [WORD_BITS-1:0]         res_r;
  logic                         err_r;

  logic [WORD_BITS-1:0]         out_value_r;
  logic [CW-1:0]                out_count_r;
  logic                         out_err_r;

  logic [AW-1:0]        pos_a;
  logic [AW-1:0]        idx_a;
  logic                 mem_we;
  logic                 mem_re;
  logic [AW-1:0]        waddr;
  logic [AW-1:0]        raddr;
  logic [WORD_BITS-1:0] wdata;
  logic [CMPW-1:0]      cnt_ext;

  assign pos_a   = pos_r[AW-1:0];
  assign idx_a   = idx_r[AW-1:0];
  assign cnt_ext = CMPW'(count_r);

  always_comb begin
    sts            = '0;
    sts.is_ins     = (op_r == iidl_pkg::OP_INSERT);
    sts.is_del     = (op_r == iidl_pkg::OP_DELETE);
    sts.is_get     = (op_r == iidl_pkg::OP_GET);
    sts.is_set     = (op_r == iidl_pkg::OP_SET);
    sts.is_clr     = (op_r == iidl_pkg::OP_CLEAR);
    sts.ins_at_pos = (CMPW'(idx_r) == pos_r);
    sts.del_last   = ((idx_r + 1'b1) == count_r);
    unique case (op_r)
      iidl_pkg::OP_INSERT: begin
        sts.err = (pos_r > cnt_ext) || (count_r == CW'(CAPACITY));
      end
      iidl_pkg::OP_DELETE,
      iidl_pkg::OP_GET,
      iidl_pkg::OP_SET: begin
        sts.err = (pos_r >= cnt_ext);
      end
      default: begin
        sts.err = 1'b0;
      end
    endcase
  end

  assign mem_we = cmd.set_wr | cmd.ins_put | cmd.wr_up | cmd.wr_dn;
  assign mem_re = cmd.rd_pos | cmd.rd_prev | cmd.rd_next;
  assign waddr  = (cmd.set_wr | cmd.ins_put) ? pos_a : idx_a;
  assign wdata  = (cmd.set_wr | cmd.ins_put) ? val_r : rdata_r;

  always_comb begin
    priority if (cmd.rd_pos) begin
      raddr = pos_a;
    end else if (cmd.rd_prev) begin
      raddr = idx_a - AW'(1);
    end else begin
      raddr = idx_a + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.clr_cnt) begin
      count_r <= '0;
    end else if (cmd.ins_put) begin
      count_r <= count_r + 1'b1;
    end else if (cmd.cnt_dec) begin
      count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= in_op;
      pos_r <= CMPW'(in_position);
      val_r <= WORD_BITS'(in_value_in);
    end
    if (cmd.idx_from_cnt) begin
      idx_r <= count_r;
    end else if (cmd.idx_from_pos) begin
      idx_r <= CW'(pos_r);
    end else if (cmd.wr_up) begin
      idx_r <= idx_r - 1'b1;
    end else if (cmd.wr_dn) begin
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.load_err) begin
      err_r <= sts.err;
      res_r <= '0;
    end else if (cmd.res_cap) begin
      res_r <= rdata_r;
    end
    if (cmd.load_out) begin
      out_value_r <= res_r;
      out_count_r <= count_r;
      out_err_r   <= err_r;
    end
  end

  assign out_value_out   = iidl_pkg::VALUE_BITS'(out_value_r);
  assign out_entry_count = iidl_pkg::COUNT_BITS'(out_count_r);
  assign out_range_error = out_err_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      (count_r == '0) || (count_r == $past(count_r) + 1'b1) ||
      (count_r == $past(count_r) - 1'b1))
    else $error("entry count jumped");

endmodule

// File: rtl/core/iidl_ctrl.sv
module iidl_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output iidl_pkg::cmd_t cmd,
  input  iidl_pkg::sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_CHK,
    S_INS_WR,
    S_GET_CAP,
    S_DEL_CAP,
    S_DEL_CHK,
    S_DEL_WR,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        cmd.latch = in_valid;
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.load_err = 1'b1;
        priority if (sts.err) begin
          state_nxt = S_DONE;
        end else if (sts.is_ins) begin
          cmd.idx_from_cnt = 1'b1;
          state_nxt        = S_INS_CHK;
        end else if (sts.is_del) begin
          cmd.rd_pos       = 1'b1;
          cmd.idx_from_pos = 1'b1;
          state_nxt        = S_DEL_CAP;
        end else if (sts.is_get) begin
          cmd.rd_pos = 1'b1;
          state_nxt  = S_GET_CAP;
        end else begin
          cmd.set_wr  = sts.is_set;
          cmd.clr_cnt = sts.is_clr;
          state_nxt   = S_DONE;
        end
      end
      S_INS_CHK: begin
        if (sts.ins_at_pos) begin
          cmd.ins_put = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.rd_prev = 1'b1;
          state_nxt   = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.wr_up = 1'b1;
        state_nxt = S_INS_CHK;
      end
      S_GET_CAP: begin
        cmd.res_cap = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DEL_CAP: begin
        cmd.res_cap = 1'b1;
        state_nxt   = S_DEL_CHK;
      end
      S_DEL_CHK: begin
        if (sts.del_last) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.rd_next = 1'b1;
          state_nxt   = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        cmd.wr_dn = 1'b1;
        state_nxt = S_DEL_CHK;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside done state");

  a_shift_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS_WR || state_r == S_DEL_WR) |->
      ($past(state_r) == S_INS_CHK || $past(state_r) == S_DEL_CHK))
    else $error("shift write without preceding read");

endmodule

// File: rtl/core/indexed_insert_delete_list.sv
// Items are decoded and range checked; error, set, clear or unknown op go to done.
// Get reads the entry at position; insert and delete shift entries one at a time
// through the entry memory, each by a read state and a write state.
// Result loads once the output is free, valid as the block returns to idle for the next item.
// Synchronous active-low reset empties the list; entry memory is not cleared.
module indexed_insert_delete_list #(
  parameter int CAPACITY  = iidl_pkg::CAPACITY_DEF,
  parameter int WORD_BITS = iidl_pkg::WORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [iidl_pkg::OP_BITS-1:0]    in_op,
  input  logic [iidl_pkg::POS_BITS-1:0]   in_position,
  input  logic [iidl_pkg::VALUE_BITS-1:0] in_value_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [iidl_pkg::VALUE_BITS-1:0] out_value_out,
  output logic [iidl_pkg::COUNT_BITS-1:0] out_entry_count,
  output logic                            out_range_error
);

  iidl_pkg::cmd_t cmd;
  iidl_pkg::sts_t sts;

  iidl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  iidl_datapath #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_op           (in_op),
    .in_position     (in_position),
    .in_value_in     (in_value_in),
    .out_value_out   (out_value_out),
    .out_entry_count (out_entry_count),
    .out_range_error (out_range_error)
  );

endmodule
